### design/smcs_pkg.sv
package smcs_pkg;

    // field and register widths
    localparam int DIM_W    = 16;
    localparam int BLK_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int LAYER_W  = 12;
    localparam int SAMP_W   = 6;
    localparam int MIPC_W   = 5;
    localparam int SIZE_W   = 32;
    localparam int STAT_W   = 2;
    localparam int OPB_W    = 16;
    localparam int CFG_IDX_W = 3;

    // ceiling division: numerator is dim + block - 1, padded to whole steps
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = (DIM_W + 1 + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_W      = DIV_CYCLES * DIV_STEPS;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);

    localparam int CUBE_FACES = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_PER_BLK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANAR_YUV   = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_FMT = 2'd1,
        ST_OVF     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DLOAD,
        S_DIV,
        S_MUL,
        S_LAYER,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        DSEL_W = 2'd0,
        DSEL_H = 2'd1,
        DSEL_D = 2'd2
    } dsel_t;

endpackage

### design/smcs_div_step.sv
module smcs_div_step (
    input  logic [smcs_pkg::BLK_W-1:0] rem_in,
    input  logic [smcs_pkg::NUM_W-1:0] num_in,
    input  logic [smcs_pkg::BLK_W-1:0] den,
    output logic [smcs_pkg::BLK_W-1:0] rem_out,
    output logic [smcs_pkg::NUM_W-1:0] num_out
);
    import smcs_pkg::*;

    // run DIV_STEPS restoring steps: numerator shifts out at the top, quotient in at the bottom
    always_comb
    begin
        logic [BLK_W:0]   t;
        logic [BLK_W-1:0] r;
        logic [NUM_W-1:0] n;
        r = rem_in;
        n = num_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, n[NUM_W-1]};
            n = {n[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den})
            begin
                t    = t - {1'b0, den};
                n[0] = 1'b1;
            end
            r = t[BLK_W-1:0];
        end
        rem_out = r;
        num_out = n;
    end

endmodule

### design/smcs_mul_sat.sv
module smcs_mul_sat (
    input  logic [smcs_pkg::SIZE_W-1:0] a,
    input  logic [smcs_pkg::OPB_W-1:0]  b,
    output logic [smcs_pkg::SIZE_W-1:0] res,
    output logic                        over
);
    import smcs_pkg::*;

    logic [SIZE_W+OPB_W-1:0] prod;

    // saturate the product to 32 bits and flag anything above
    assign prod = a * b;
    assign over = |prod[SIZE_W+OPB_W-1:SIZE_W];
    assign res  = over ? {SIZE_W{1'b1}} : prod[SIZE_W-1:0];

endmodule

### design/surface_mip_chain_size_unit.sv
// An input beat runs the steps below for each mip level, then a layer multiply and the
// result beat (a mip count of 0 skips the levels, an invalid format goes straight to it).
// Each level runs three ceiling divides (a load state, then the divide state through
// one 4-bit-per-cycle divider slice), then four passes through one 32x16 saturating multiplier.
// One surface at a time: the next beat is taken once the result is in the output register.
// Reset: sequencer idle, output empty, format registers at their documented defaults.
module surface_mip_chain_size_unit #(
    parameter int MAX_MIPS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [smcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smcs_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [smcs_pkg::DIM_W-1:0]     base_width,
    input  logic [smcs_pkg::DIM_W-1:0]     base_height,
    input  logic [smcs_pkg::DIM_W-1:0]     base_depth,
    input  logic [smcs_pkg::MIPC_W-1:0]    mip_count,
    input  logic [smcs_pkg::LAYER_W-1:0]   array_layers,
    input  logic [smcs_pkg::SAMP_W-1:0]    sample_count,
    input  logic                           is_cubemap,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [smcs_pkg::SIZE_W-1:0]    size_bytes,
    output logic [smcs_pkg::STAT_W-1:0]    status
);
    import smcs_pkg::*;

    localparam int MIPS_W = $clog2(MAX_MIPS + 1);

    // format registers
    logic [BLK_W-1:0]  blk_w_reg, blk_h_reg, blk_d_reg;
    logic [BYTE_W-1:0] bpb_reg, pitch_reg;
    logic              planar_reg;

    state_t            state_reg, state_next;
    dsel_t             sel_reg, sel_next;
    logic [1:0]        mstep_reg, mstep_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [MIPS_W-1:0] mips_reg, mips_next;

    logic [DIM_W-1:0]   w_reg, w_next, h_reg, h_next, d_reg, d_next;
    logic [DIM_W-1:0]   bw_reg, bw_next, bh_reg, bh_next, bd_reg, bd_next;
    logic [LAYER_W-1:0] layers_reg, layers_next;
    logic [SAMP_W-1:0]  samp_reg, samp_next;
    logic [BLK_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [SIZE_W-1:0]  p_reg, p_next, total_reg, total_next;
    logic               p_big_reg, p_big_next, total_big_reg, total_big_next;
    logic               ovf_reg, ovf_next;
    logic [SIZE_W-1:0]  res_size_reg, res_size_next;
    status_t            res_stat_reg, res_stat_next;

    logic               out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0]  out_size_reg, out_size_next;
    status_t            out_stat_reg, out_stat_next;

    logic [BLK_W-1:0]   den_eff, rem_step;
    logic [NUM_W-1:0]   num_step, num_load;
    logic [DIM_W-1:0]   dim_src, dim_eff;
    logic [SIZE_W-1:0]  mul_a, mul_res;
    logic [OPB_W-1:0]   mul_b;
    logic               mul_over;
    logic [SIZE_W:0]    sum;
    logic [MIPS_W-1:0]  mips_sat;
    logic [LAYER_W-1:0] layers_in;
    logic [SAMP_W-1:0]  samp_in;

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_w_reg  <= BLK_W'(1);
            blk_h_reg  <= BLK_W'(1);
            blk_d_reg  <= BLK_W'(1);
            bpb_reg    <= BYTE_W'(4);
            pitch_reg  <= BYTE_W'(4);
            planar_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_WIDTH:   blk_w_reg  <= cfg_data[BLK_W-1:0];
                REG_BLOCK_HEIGHT:  blk_h_reg  <= cfg_data[BLK_W-1:0];
                REG_BLOCK_DEPTH:   blk_d_reg  <= cfg_data[BLK_W-1:0];
                REG_BYTES_PER_BLK: bpb_reg    <= cfg_data;
                REG_PITCH_PER_BLK: pitch_reg  <= cfg_data;
                REG_PLANAR_YUV:    planar_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // select the dimension and block size for the current divide
    always_comb
    begin
        unique case (sel_reg)
            DSEL_W:  begin dim_src = w_reg; den_eff = blk_w_reg; end
            DSEL_H:  begin dim_src = h_reg; den_eff = blk_h_reg; end
            default: begin dim_src = d_reg; den_eff = blk_d_reg; end
        endcase
        if (den_eff == '0)
            den_eff = BLK_W'(1);
    end

    assign dim_eff  = (dim_src == '0) ? DIM_W'(1) : dim_src;
    assign num_load = NUM_W'(dim_eff) + NUM_W'(den_eff) - NUM_W'(1);

    smcs_div_step u_div (
        .rem_in  (rem_reg),
        .num_in  (num_reg),
        .den     (den_eff),
        .rem_out (rem_step),
        .num_out (num_step)
    );

    // feed the shared multiplier from the sequencer step
    always_comb
    begin
        mul_a = p_reg;
        mul_b = OPB_W'(samp_reg);
        if (state_reg == S_LAYER)
        begin
            mul_a = total_reg;
            mul_b = OPB_W'(layers_reg);
        end
        else
        begin
            unique case (mstep_reg)
                2'd0:
                begin
                    mul_a = SIZE_W'(bw_reg);
                    mul_b = planar_reg ? bh_reg : OPB_W'(pitch_reg);
                end
                2'd1:    mul_b = planar_reg ? bd_reg : bh_reg;
                2'd2:    mul_b = planar_reg ? OPB_W'(bpb_reg) : bd_reg;
                default: mul_b = OPB_W'(samp_reg);
            endcase
        end
    end

    smcs_mul_sat u_mul (
        .a    (mul_a),
        .b    (mul_b),
        .res  (mul_res),
        .over (mul_over)
    );

    assign sum       = {1'b0, total_reg} + {1'b0, mul_res};
    assign mips_sat  = (32'(mip_count) > MAX_MIPS) ? MIPS_W'(MAX_MIPS) : MIPS_W'(mip_count);
    assign samp_in   = (sample_count == '0) ? SAMP_W'(1) : sample_count;
    assign layers_in = (array_layers != '0) ? array_layers :
                       (is_cubemap ? LAYER_W'(CUBE_FACES) : LAYER_W'(1));

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        mstep_next     = mstep_reg;
        dcnt_next      = dcnt_reg;
        mips_next      = mips_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        d_next         = d_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        bd_next        = bd_reg;
        layers_next    = layers_reg;
        samp_next      = samp_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        p_next         = p_reg;
        p_big_next     = p_big_reg;
        total_next     = total_reg;
        total_big_next = total_big_reg;
        ovf_next       = ovf_reg;
        res_size_next  = res_size_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_size_next  = out_size_reg;
        out_stat_next  = out_stat_reg;

        // drop the result beat once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    w_next         = base_width;
                    h_next         = base_height;
                    d_next         = base_depth;
                    mips_next      = mips_sat;
                    layers_next    = layers_in;
                    samp_next      = samp_in;
                    sel_next       = DSEL_W;
                    total_next     = '0;
                    total_big_next = 1'b0;
                    ovf_next       = 1'b0;
                    if (bpb_reg == '0)
                    begin
                        res_size_next = '0;
                        res_stat_next = ST_BAD_FMT;
                        state_next    = S_FIN;
                    end
                    else if (mips_sat == '0)
                        state_next = S_LAYER;
                    else
                        state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                rem_next   = '0;
                num_next   = num_load;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = rem_step;
                num_next  = num_step;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_CYCLES - 1))
                begin
                    unique case (sel_reg)
                        DSEL_W:
                        begin
                            bw_next    = num_step[DIM_W-1:0];
                            sel_next   = DSEL_H;
                            state_next = S_DLOAD;
                        end
                        DSEL_H:
                        begin
                            bh_next    = num_step[DIM_W-1:0];
                            sel_next   = DSEL_D;
                            state_next = S_DLOAD;
                        end
                        default:
                        begin
                            bd_next    = num_step[DIM_W-1:0];
                            mstep_next = 2'd0;
                            state_next = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 2'd1;
                unique case (mstep_reg)
                    2'd0:
                    begin
                        p_next     = mul_res;
                        p_big_next = mul_over;
                    end
                    2'd1, 2'd2:
                    begin
                        p_next     = mul_res;
                        p_big_next = p_big_reg | mul_over;
                    end
                    default:
                    begin
                        // scale by samples, accumulate and advance to the next level or the layer step
                        ovf_next       = ovf_reg | p_big_reg;
                        total_next     = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
                        total_big_next = total_big_reg | mul_over | sum[SIZE_W];
                        w_next         = w_reg >> 1;
                        h_next         = h_reg >> 1;
                        d_next         = d_reg >> 1;
                        mips_next      = mips_reg - MIPS_W'(1);
                        sel_next       = DSEL_W;
                        if (mips_reg == MIPS_W'(1))
                            state_next = S_LAYER;
                        else
                            state_next = S_DLOAD;
                    end
                endcase
            end
            S_LAYER:
            begin
                if (ovf_reg || total_big_reg || mul_over)
                begin
                    res_size_next = '0;
                    res_stat_next = ST_OVF;
                end
                else
                begin
                    res_size_next = mul_res;
                    res_stat_next = ST_OK;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_size_next  = res_size_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        mstep_reg     <= mstep_next;
        dcnt_reg      <= dcnt_next;
        mips_reg      <= mips_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        d_reg         <= d_next;
        bw_reg        <= bw_next;
        bh_reg        <= bh_next;
        bd_reg        <= bd_next;
        layers_reg    <= layers_next;
        samp_reg      <= samp_next;
        rem_reg       <= rem_next;
        num_reg       <= num_next;
        p_reg         <= p_next;
        p_big_reg     <= p_big_next;
        total_reg     <= total_next;
        total_big_reg <= total_big_next;
        ovf_reg       <= ovf_next;
        res_size_reg  <= res_size_next;
        res_stat_reg  <= res_stat_next;
        out_size_reg  <= out_size_next;
        out_stat_reg  <= out_stat_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign size_bytes = out_size_reg;
    assign status     = out_stat_reg;

endmodule
